FILE: hw/rtl/dtq_pkg.sv
// ---------------------------------------------------------------------------
// dtq_pkg: shared definitions for the deadline timer queue
// Holds sizing constants, opcode and register codes, the controller state
// type and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package dtq_pkg;

    // Default queue size and configuration reset value.
    localparam int unsigned DTQ_QUEUE_DEPTH = 16;
    localparam logic [15:0] DTQ_REARM_RESET = 16'd15;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_SET    = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    // Register index decoded from the word address.
    localparam logic REG_REARM_DELAY = 1'b0;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_EXP_START,
        ST_EXP_HEAD,
        ST_EXP_READ,
        ST_EXP_CMP,
        ST_EXP_REARM
    } dtq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch a new item and clear the result
        logic rd_cur;     // read the entry at the current index
        logic rd_prev;    // read the entry just below the current index
        logic set_now;    // head deadline becomes the current time
        logic inc_idx;    // step the scan index up
        logic pop;        // drop the scanned deadlines from the head
        logic gap;        // arm the alarm for the gap to the new head
        logic wr_rearm;   // insert the default re-arm deadline
        logic wr_key;     // write the new deadline at the current index
        logic wr_shift;   // move the read entry up one slot
        logic load_out;   // move the result into the output register
    } dtq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op;
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic idx_lt_cnt;
        logic rdata_gt_key;
        logic rdata_eq_now;
        logic out_busy;
        logic finish;     // result is complete and waits for the output
    } dtq_status_t;

endpackage

FILE: hw/rtl/deadline_timer_queue.sv
// Sequence: a set request scans down from the tail, shifting each later deadline up one slot,
// then writes the new deadline; an expiry moves the current time to the head deadline and
// pops it together with every duplicate. Full and empty cases finish straight from idle.
// Throughput: one item at a time; the next is accepted once the result is registered.
// Reset: current time, count and head clear, the re-arm delay returns to 15; the
// deadline memory is not cleared since only slots below the count are ever read.
// ---------------------------------------------------------------------------
// deadline_timer_queue: sorted queue of absolute timer deadlines
// Inserts deadlines in order, pops expired ones and reports alarm re-arming.
// ---------------------------------------------------------------------------
module deadline_timer_queue
#(
    parameter int unsigned QUEUE_DEPTH = dtq_pkg::DTQ_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] delay_seconds
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] expired_count, [5] arm_alarm,
                                   // [21:6] alarm_delay, [22] full_drop,
                                   // [23] empty_fault, [28:24] pending_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dtq_pkg::dtq_cmd_t    cmd;
    dtq_pkg::dtq_status_t status;
    logic [15:0]          rearm_delay;
    logic                 finish;

    // Configuration registers.
    dtq_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rearm_delay (rearm_delay)
    );

    // Sequencing controller.
    dtq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .finish   (finish)
    );

    // Queue datapath.
    dtq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .finish        (finish),
        .status        (status),
        .opcode        (s_tuser),
        .delay_seconds (s_tdata),
        .rearm_delay   (rearm_delay),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

FILE: hw/rtl/dtq_cfg_regs.sv
// ---------------------------------------------------------------------------
// dtq_cfg_regs: configuration register file
// APB-style slave holding the default re-arm delay, with read back.
// ---------------------------------------------------------------------------
module dtq_cfg_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] rearm_delay
);

    logic [15:0] rearm_delay_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register write; writes to other addresses are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_delay_reg <= dtq_pkg::DTQ_REARM_RESET;
        end
        else if (wr_en && (paddr[2] == dtq_pkg::REG_REARM_DELAY))
        begin
            rearm_delay_reg <= pwdata[15:0];
        end
    end

    // Read back.
    always_comb
    begin
        if (paddr[2] == dtq_pkg::REG_REARM_DELAY)
        begin
            prdata = {16'd0, rearm_delay_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign rearm_delay = rearm_delay_reg;

endmodule

FILE: hw/rtl/dtq_ctrl.sv
// ---------------------------------------------------------------------------
// dtq_ctrl: sequencing controller
// Walks the queue one entry at a time, a read state then a compare state per entry,
// for sorted insert and for the duplicate pop on expiry, issuing commands to the datapath.
// ---------------------------------------------------------------------------
module dtq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dtq_pkg::dtq_status_t status,
    output dtq_pkg::dtq_cmd_t    cmd,
    output logic                 finish
);

    dtq_pkg::dtq_state_t state_reg;
    dtq_pkg::dtq_state_t state_next;
    logic                finish_reg;
    logic                finish_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dtq_pkg::ST_IDLE;
            finish_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            finish_reg <= finish_next;
        end
    end

    assign finish = finish_reg;

    // Next state. A finished item waits in idle until the output takes it.
    always_comb
    begin
        state_next  = state_reg;
        finish_next = finish_reg;
        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (finish_reg)
                begin
                    if (!status.out_busy)
                    begin
                        finish_next = 1'b0;
                    end
                end
                else if (s_tvalid)
                begin
                    if (status.in_op == dtq_pkg::OP_SET)
                    begin
                        if (status.cnt_full)
                        begin
                            finish_next = 1'b1;
                        end
                        else
                        begin
                            state_next = dtq_pkg::ST_INS_READ;
                        end
                    end
                    else if (status.cnt_zero)
                    begin
                        finish_next = 1'b1;
                    end
                    else
                    begin
                        state_next = dtq_pkg::ST_EXP_START;
                    end
                end
            end
            dtq_pkg::ST_INS_READ:
            begin
                if (status.idx_zero)
                begin
                    state_next  = dtq_pkg::ST_IDLE;
                    finish_next = 1'b1;
                end
                else
                begin
                    state_next = dtq_pkg::ST_INS_CMP;
                end
            end
            dtq_pkg::ST_INS_CMP:
            begin
                if (status.rdata_gt_key)
                begin
                    state_next = dtq_pkg::ST_INS_READ;
                end
                else
                begin
                    state_next  = dtq_pkg::ST_IDLE;
                    finish_next = 1'b1;
                end
            end
            dtq_pkg::ST_EXP_START:
            begin
                state_next = dtq_pkg::ST_EXP_HEAD;
            end
            dtq_pkg::ST_EXP_HEAD:
            begin
                state_next = dtq_pkg::ST_EXP_READ;
            end
            dtq_pkg::ST_EXP_READ:
            begin
                if (status.idx_lt_cnt)
                begin
                    state_next = dtq_pkg::ST_EXP_CMP;
                end
                else
                begin
                    state_next = dtq_pkg::ST_EXP_REARM;
                end
            end
            dtq_pkg::ST_EXP_CMP:
            begin
                if (status.rdata_eq_now)
                begin
                    state_next = dtq_pkg::ST_EXP_READ;
                end
                else
                begin
                    state_next  = dtq_pkg::ST_IDLE;
                    finish_next = 1'b1;
                end
            end
            dtq_pkg::ST_EXP_REARM:
            begin
                state_next  = dtq_pkg::ST_IDLE;
                finish_next = 1'b1;
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                s_tready     = ~finish_reg;
                cmd.accept   = ~finish_reg & s_tvalid;
                cmd.load_out = finish_reg & ~status.out_busy;
            end
            dtq_pkg::ST_INS_READ:
            begin
                cmd.wr_key  = status.idx_zero;
                cmd.rd_prev = ~status.idx_zero;
            end
            dtq_pkg::ST_INS_CMP:
            begin
                cmd.wr_shift = status.rdata_gt_key;
                cmd.wr_key   = ~status.rdata_gt_key;
            end
            dtq_pkg::ST_EXP_START:
            begin
                cmd.rd_cur = 1'b1;
            end
            dtq_pkg::ST_EXP_HEAD:
            begin
                cmd.set_now = 1'b1;
            end
            dtq_pkg::ST_EXP_READ:
            begin
                cmd.rd_cur = status.idx_lt_cnt;
                cmd.pop    = ~status.idx_lt_cnt;
            end
            dtq_pkg::ST_EXP_CMP:
            begin
                cmd.inc_idx = status.rdata_eq_now;
                cmd.pop     = ~status.rdata_eq_now;
                cmd.gap     = ~status.rdata_eq_now;
            end
            dtq_pkg::ST_EXP_REARM:
            begin
                cmd.wr_rearm = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dtq_datapath.sv
// ---------------------------------------------------------------------------
// dtq_datapath: deadline storage and arithmetic
// Circular deadline memory with a head pointer, current time, entry count,
// scan index, result fields and the output register.
// ---------------------------------------------------------------------------
module dtq_datapath
#(
    parameter int unsigned QUEUE_DEPTH = dtq_pkg::DTQ_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtq_pkg::dtq_cmd_t    cmd,
    input  logic                 finish,
    output dtq_pkg::dtq_status_t status,
    input  logic                 opcode,
    input  logic [15:0]          delay_seconds,
    input  logic [15:0]          rearm_delay,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    // Deadline memory, read data registered.
    logic [31:0]   mem [QUEUE_DEPTH];
    logic [31:0]   rdata_reg;

    // Queue state.
    logic [31:0]   now_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] head_reg;

    // Per-item working registers.
    logic [CW-1:0] idx_reg;
    logic [31:0]   key_reg;
    logic [15:0]   delay_reg;
    logic [4:0]    res_fired_reg;
    logic          res_arm_reg;
    logic [15:0]   res_delay_reg;
    logic          res_full_reg;
    logic          res_fault_reg;

    // Output register.
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;

    logic [AW-1:0] addr_cur;
    logic [AW-1:0] addr_prev;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    logic [31:0]   gap_diff;
    logic [15:0]   gap_sat;
    logic [4:0]    fired_sat;
    logic [4:0]    pending_sat;
    logic [31:0]   rearm_deadline;

    // Logical slot to physical address, wrapping once past the end.
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                 input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Clamp a count to the five-bit result field.
    function automatic logic [4:0] sat31(input logic [CW-1:0] v);
        logic [CW+4:0] ext;
        ext = {5'd0, v};
        if (ext > (CW+5)'(31))
        begin
            return 5'd31;
        end
        return ext[4:0];
    endfunction

    assign addr_cur       = slot_addr(head_reg, idx_reg);
    assign addr_prev      = slot_addr(head_reg, idx_reg - CW'(1));
    assign rd_addr        = cmd.rd_prev ? addr_prev : addr_cur;
    assign wr_en          = cmd.wr_key | cmd.wr_shift | cmd.wr_rearm;
    assign wr_addr        = cmd.wr_rearm ? head_reg : addr_cur;
    assign rearm_deadline = now_reg + {16'd0, rearm_delay};

    always_comb
    begin
        priority if (cmd.wr_rearm)
        begin
            wr_data = rearm_deadline;
        end
        else if (cmd.wr_shift)
        begin
            wr_data = rdata_reg;
        end
        else
        begin
            wr_data = key_reg;
        end
    end

    assign gap_diff    = rdata_reg - now_reg;
    assign gap_sat     = (|gap_diff[31:16]) ? 16'hFFFF : gap_diff[15:0];
    assign fired_sat   = sat31(idx_reg);
    assign pending_sat = sat31(count_reg);

    // Memory port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_cur || cmd.rd_prev)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Queue state: current time, count and head pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= 32'd0;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            if (cmd.set_now)
            begin
                now_reg <= rdata_reg;
            end
            if (cmd.pop)
            begin
                head_reg  <= addr_cur;
                count_reg <= count_reg - idx_reg;
            end
            else if (cmd.wr_rearm)
            begin
                count_reg <= CW'(1);
            end
            else if (cmd.wr_key)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Working registers and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg       <= now_reg + {16'd0, delay_seconds};
            delay_reg     <= delay_seconds;
            res_fired_reg <= 5'd0;
            res_arm_reg   <= 1'b0;
            res_delay_reg <= 16'd0;
            if (opcode == dtq_pkg::OP_SET)
            begin
                idx_reg       <= count_reg;
                res_full_reg  <= status.cnt_full;
                res_fault_reg <= 1'b0;
            end
            else
            begin
                idx_reg       <= '0;
                res_full_reg  <= 1'b0;
                res_fault_reg <= status.cnt_zero;
            end
        end
        if (cmd.set_now)
        begin
            idx_reg <= CW'(1);
        end
        if (cmd.inc_idx)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.wr_shift)
        begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (cmd.wr_key && status.idx_zero)
        begin
            // New deadline lands at the head: reprogram the alarm.
            res_arm_reg   <= 1'b1;
            res_delay_reg <= delay_reg;
        end
        if (cmd.pop)
        begin
            res_fired_reg <= fired_sat;
        end
        if (cmd.gap)
        begin
            res_arm_reg   <= 1'b1;
            res_delay_reg <= gap_sat;
        end
        if (cmd.wr_rearm)
        begin
            res_arm_reg   <= 1'b1;
            res_delay_reg <= rearm_delay;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {3'd0, pending_sat, res_fault_reg, res_full_reg,
                             res_delay_reg, res_arm_reg, res_fired_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status to the controller.
    always_comb
    begin
        status              = '0;
        status.in_op        = opcode;
        status.cnt_zero     = (count_reg == '0);
        status.cnt_full     = (count_reg >= CW'(QUEUE_DEPTH));
        status.idx_zero     = (idx_reg == '0);
        status.idx_lt_cnt   = (idx_reg < count_reg);
        status.rdata_gt_key = (rdata_reg > key_reg);
        status.rdata_eq_now = (rdata_reg == now_reg);
        status.out_busy     = out_valid_reg & ~m_tready;
        status.finish       = finish;
    end

endmodule
